// ----- hw/rtl/fir_filter_direct_form_core_macros.svh -----
// Assertion macros shared by the FIR filter RTL.
`ifndef FIR_FILTER_DIRECT_FORM_CORE_MACROS_SVH
`define FIR_FILTER_DIRECT_FORM_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fdf_pkg.sv -----
// Types and constants shared by the FIR filter modules.
package fdf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 7;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 38;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Control broadcast from the sequencer to every cell of the ring.
    typedef struct packed {
        logic             rotate;
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] load_index;
        sample_t          load_value;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/fdf_cell.sv -----
// One tap cell: holds a delay-line sample and its coefficient.
module fdf_cell
    import fdf_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  sample_t    in_sample,
    input  sample_t    in_coef,
    output sample_t    sample,
    output sample_t    coef
);

    sample_t sample_reg;
    sample_t sample_next;
    sample_t coef_reg;
    sample_t coef_next;
    logic    load_hit;

    assign load_hit = ctrl.load && (32'(ctrl.load_index) == 32'(INDEX));

    always_comb
    begin
        sample_next = sample_reg;
        coef_next   = coef_reg;
        if (ctrl.rotate)
        begin
            sample_next = in_sample;
            coef_next   = in_coef;
        end
        else if (ctrl.shift)
        begin
            sample_next = in_sample;
        end
        else if (load_hit)
        begin
            coef_next = ctrl.load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

// ----- hw/rtl/fdf_mac.sv -----
// Multiply-accumulate unit fed by the head cell of the ring.
module fdf_mac
    import fdf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    mul_en,
    input  sample_t                 sample,
    input  sample_t                 coef,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod_next = sample * coef;

    // The sum wraps at the accumulator width; with the default tap count it never does.
    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= mul_en;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hw/rtl/fir_filter_direct_form_core.sv -----
// Direct-form FIR filter: a ring of TAPS cells, each holding one delay-line sample and
// one Q1.15 coefficient, rotates past a single multiply-accumulate unit, one tap per
// cycle. A coefficient-load item gives no result and leaves the block idle. A sample item
// gives the exact sum over the previous TAPS samples (the new sample is not in it) and
// then enters the delay line; the block is busy with it through the tap sweep, the shift
// of the delay line and the output state, which holds while the output register is full.
// The result waits in an output register, and a new item is accepted while it waits.
// After reset all samples and coefficients are zero.
`include "fir_filter_direct_form_core_macros.svh"

module fir_filter_direct_form_core
    import fdf_pkg::*;
#(
    parameter int TAPS = 100
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // opcode [0], coef_index [7:1], value [23:8]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // filtered [37:0], zero [39:38]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    sample_t                 new_sample_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [ACC_W-1:0]        m_data_reg;
    logic                    in_opcode;
    logic [IDX_W-1:0]        in_coef_index;
    sample_t                 in_value;
    logic                    accept;
    logic                    out_free;
    cell_ctrl_t              ctrl;
    sample_t                 cell_sample [TAPS];
    sample_t                 cell_coef   [TAPS];
    logic signed [ACC_W-1:0] acc;

    assign in_opcode     = s_axis_tdata[0];
    assign in_coef_index = s_axis_tdata[IDX_W:1];
    assign in_value      = s_axis_tdata[S_TDATA_W-1:IDX_W+1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        ctrl.rotate     = (state_reg == ST_RUN);
        ctrl.shift      = (state_reg == ST_SHIFT);
        ctrl.load       = accept && (in_opcode == OP_LOAD);
        ctrl.load_index = in_coef_index;
        ctrl.load_value = in_value;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_opcode == OP_FILTER))
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_sample_reg <= in_value;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_data_reg <= acc;
        end
    end

    // Cell 0 holds the oldest sample. Every cell takes from its right neighbor; the last
    // cell closes the ring while rotating and takes the new sample while shifting.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        sample_t nb_sample;
        sample_t nb_coef;

        if (k == TAPS - 1)
        begin : g_tail
            assign nb_sample = ctrl.shift ? new_sample_reg : cell_sample[0];
            assign nb_coef   = cell_coef[0];
        end
        else
        begin : g_body
            assign nb_sample = cell_sample[k+1];
            assign nb_coef   = cell_coef[k+1];
        end

        fdf_cell #(
            .INDEX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_sample (nb_sample),
            .in_coef   (nb_coef),
            .sample    (cell_sample[k]),
            .coef      (cell_coef[k])
        );
    end

    fdf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (accept),
        .mul_en (ctrl.rotate),
        .sample (cell_sample[0]),
        .coef   (cell_coef[0]),
        .acc    (acc)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-ACC_W){1'b0}}, m_data_reg};

    `FDF_ASSERT_NEXT(a_filter_starts_run, accept && (in_opcode == OP_FILTER), state_reg == ST_RUN, "filter item did not start the tap sweep")
    `FDF_ASSERT_NEXT(a_load_stays_idle, accept && (in_opcode == OP_LOAD), state_reg == ST_IDLE, "coefficient load left the idle state")
    `FDF_ASSERT_NOW(a_cnt_in_range, state_reg == ST_RUN, cnt_reg <= CNT_W'(TAPS - 1), "tap counter beyond the last cell")
    `FDF_ASSERT_NEXT(a_result_posted, (state_reg == ST_OUT) && out_free, m_axis_tvalid && (state_reg == ST_IDLE), "finished sum was not posted")

endmodule

// ----- verif/tb_fir_filter_direct_form_core.sv -----
// Self-checking testbench for the direct-form FIR filter core over its stream ports.
module tb_fir_filter_direct_form_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fdf_pkg::*;

    localparam int TAPS        = 100;
    localparam int ITEM_CYCLES = TAPS + 3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 800;
    localparam int HOLD_AFTER  = 300;
    localparam int PHASE_ITEMS = 640;

    typedef struct {
        logic                  op;
        logic [IDX_W-1:0]      idx;
        logic [SAMPLE_W-1:0]   val;
        bit                    known;
        logic [ACC_W-1:0]      want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the filter state.
    logic signed [SAMPLE_W-1:0] shadow_delay [TAPS];
    logic signed [SAMPLE_W-1:0] shadow_coef [TAPS];
    int                         shadow_oldest;

    logic [ACC_W-1:0] pending_sums [$];
    stim_row_t        stim_rows [$];
    logic [ACC_W-1:0] got_sum;
    int               mismatches = 0;
    int               sums_seen = 0;
    int               src_idle_pct = 0;
    int               sink_idle_pct = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;
    int               quiet_cycles = 0;

    fir_filter_direct_form_core #(
        .TAPS(TAPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Updates the shadow state for one accepted item; a sample yields the sum
    // over the delay line as it stood before the sample entered it.
    task automatic fir_predict(input logic op, input logic [IDX_W-1:0] idx,
                               input logic [SAMPLE_W-1:0] val,
                               output bit gives_sum, output logic [ACC_W-1:0] sum);
        longint acc;
        int     pos;
        begin
            gives_sum = 1'b0;
            sum = '0;
            if (op == OP_LOAD)
            begin
                if (idx < TAPS)
                    shadow_coef[idx] = val;
            end
            else
            begin
                acc = 0;
                pos = shadow_oldest;
                for (int j = 0; j < TAPS; j++)
                begin
                    acc += longint'(shadow_delay[pos]) * longint'(shadow_coef[j]);
                    pos = (pos == TAPS - 1) ? 0 : pos + 1;
                end
                sum = acc[ACC_W-1:0];
                gives_sum = 1'b1;
                shadow_delay[shadow_oldest] = val;
                shadow_oldest = (shadow_oldest == TAPS - 1) ? 0 : shadow_oldest + 1;
            end
        end
    endtask

    // Offers one item, waits for the handshake and records what it should produce.
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] val,
                             input bit known, input logic [ACC_W-1:0] want);
        bit               gives_sum;
        logic [ACC_W-1:0] sum;
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {val, idx, op};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            fir_predict(op, idx, val, gives_sum, sum);
            if (gives_sum)
                pending_sums.insert(pending_sums.size(), known ? want : sum);
        end
    endtask

    task automatic add_row(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val,
                           input bit known, input logic [ACC_W-1:0] want);
        stim_row_t r;
        begin
            r.op = op;
            r.idx = idx;
            r.val = val;
            r.known = known;
            r.want = want;
            stim_rows.insert(stim_rows.size(), r);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: pick_value = 16'h8000;
            1: pick_value = 16'h7FFF;
            2: pick_value = 16'h0000;
            3: pick_value = 16'hFFFF;
            default: pick_value = SAMPLE_W'($urandom);
        endcase
    endfunction

    // Receiver: random back-pressure, plus one long hold-off so the core backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && sums_seen >= HOLD_AFTER)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sums_seen <= sums_seen + 1;
            if (pending_sums.size() == 0)
            begin
                $error("filtered: expected nothing, got %0d",
                       $signed(m_axis_tdata[ACC_W-1:0]));
                mismatches++;
            end
            else
            begin
                got_sum = pending_sums.pop_front();
                if (m_axis_tdata[ACC_W-1:0] !== got_sum)
                begin
                    $error("filtered: expected %0d, got %0d",
                           $signed(got_sum), $signed(m_axis_tdata[ACC_W-1:0]));
                    mismatches++;
                end
                if (m_axis_tdata[M_TDATA_W-1:ACC_W] !== '0)
                begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[M_TDATA_W-1:ACC_W]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        logic             op;
        logic [IDX_W-1:0] idx;
        int               r;

        for (int i = 0; i < TAPS; i++)
        begin
            shadow_delay[i] = '0;
            shadow_coef[i] = '0;
        end
        shadow_oldest = 0;

        // Directed rows: extremes of every field, both operations, and loads
        // past the end of the table that must be ignored.
        add_row(OP_FILTER, 7'd0,   16'h7FFF, 1'b1, '0);
        add_row(OP_FILTER, 7'd0,   16'h8000, 1'b1, '0);
        add_row(OP_LOAD,   7'd99,  16'h8000, 1'b0, '0);
        add_row(OP_LOAD,   7'd0,   16'h7FFF, 1'b0, '0);
        add_row(OP_LOAD,   7'd100, 16'h1234, 1'b0, '0);
        add_row(OP_LOAD,   7'd127, 16'hFFFF, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'h0000, 1'b0, '0);
        add_row(OP_FILTER, 7'd127, 16'h0001, 1'b0, '0);
        add_row(OP_LOAD,   7'd1,   16'h5555, 1'b0, '0);
        add_row(OP_LOAD,   7'd98,  16'hAAAA, 1'b0, '0);
        add_row(OP_LOAD,   7'd64,  16'hFFFF, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'hFFFF, 1'b0, '0);
        add_row(OP_FILTER, 7'd42,  16'h5555, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'hAAAA, 1'b0, '0);
        add_row(OP_LOAD,   7'd0,   16'h0000, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'h7FFF, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'h8000, 1'b0, '0);
        add_row(OP_LOAD,   7'd63,  16'h0001, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'h3039, 1'b0, '0);
        add_row(OP_FILTER, 7'd0,   16'h0000, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  <= 33;
        sink_idle_pct <= 45;
        foreach (stim_rows[i])
            send_item(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].val,
                      stim_rows[i].known, stim_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  <= (phase == 0) ? 33 : (phase == 1) ? 45 : 0;
            sink_idle_pct <= (phase == 0) ? 45 : (phase == 1) ? 33 : 0;

            // Full table reload; the first two phases drive the sum to its
            // positive and negative extremes with a run of constant samples.
            for (int i = 0; i < TAPS; i++)
                send_item(OP_LOAD, IDX_W'(i), (phase == 2) ? pick_value() : 16'h8000,
                          1'b0, '0);
            for (int i = 0; i < TAPS + 20; i++)
                send_item(OP_FILTER, IDX_W'($urandom),
                          (phase == 0) ? 16'h8000 : (phase == 1) ? 16'h7FFF : pick_value(),
                          1'b0, '0);

            for (int n = 0; n < PHASE_ITEMS - (2 * TAPS + 20); n++)
            begin
                r = $urandom_range(99);
                if (r < 85)
                begin
                    op  = OP_FILTER;
                    idx = IDX_W'($urandom);
                end
                else if (r < 97)
                begin
                    op  = OP_LOAD;
                    idx = IDX_W'($urandom_range(TAPS - 1));
                end
                else
                begin
                    op  = OP_LOAD;
                    idx = IDX_W'($urandom_range(127, TAPS));
                end
                send_item(op, idx, pick_value(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (2 * ITEM_CYCLES) @(posedge clk);

        if (pending_sums.size() != 0)
            $error("filtered: %0d results never arrived", pending_sums.size());
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
